[sv/cbms_pkg.sv]
// Shared types, codes and constants of the CPU bus master sequencer.
package cbms_pkg;

    localparam int MAX_WORDS_DEF = 16;
    localparam int ADDR_BITS     = 24;
    localparam int WORD_W        = 16;
    localparam int DIDX_W        = 6;
    localparam int BYTES_W       = 7;
    localparam int OFFS_W        = 7;
    localparam int CMD_W         = 2;
    localparam int IN_W          = 72;
    localparam int OUT_W         = 72;

    localparam logic [ADDR_BITS-1:0] ADDR_MASK = 24'hfffffe;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_POP   = 2'd3
    } cmd_t;

    localparam logic [1:0] SIZE_NARROW = 2'b01;
    localparam logic [1:0] SIZE_WIDE   = 2'b10;

    localparam logic [1:0] LANE_NONE = 2'b00;
    localparam logic [1:0] LANE_LOW  = 2'b01;
    localparam logic [1:0] LANE_HIGH = 2'b10;
    localparam logic [1:0] LANE_BOTH = 2'b11;

    // Input word, last member in the lowest bits.
    typedef struct packed {
        logic [3:0]           pad;
        logic [3:0]           irq_lines;
        logic [WORD_W-1:0]    bus_data_in;
        logic                 not_ready_in;
        logic [WORD_W-1:0]    write_word;
        logic [5:0]           op_bytes;
        logic                 op_is_read;
        logic [ADDR_BITS-1:0] op_address;
    } in_word_t;

    // Result word, last member in the lowest bits.
    typedef struct packed {
        logic                 pad;
        logic                 overflow_flag;
        logic [WORD_W-1:0]    popped_word;
        logic [5:0]           interrupt_bits;
        logic                 has_read_data;
        logic                 idle_flag;
        logic [WORD_W-1:0]    data_out;
        logic                 data_drive;
        logic [1:0]           write_strobe;
        logic [1:0]           size_strobe;
        logic [ADDR_BITS-1:0] addr_out;
        logic                 addr_drive;
    } out_word_t;

endpackage

[sv/cbms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cbms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/cpu_bus_master_sequencer.sv]
// Top level of the CPU bus master sequencer: phase control, word buffer and output stages.
//
//  Channel   Dir  Handshake                      Contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: cmd, tdata: operation and bus samples
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: bus drive, flags and popped word
//
// One word is taken per cycle while s_axis_tready is high. A result passes the read
// stage, with the registered read port of the word buffer RAM, and then the output
// register before it appears on m_axis.
// Reset clears all control state; the word buffer is not cleared and holds no
// meaning until written, so the block is ready right after reset.
// A stalled result holds in the output register while one more word is taken
// into the read stage; s_axis_tready drops only when both stages are full.
module cpu_bus_master_sequencer #(
    parameter int MAX_WORDS = cbms_pkg::MAX_WORDS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // tdata: op_address[23:0], op_is_read[24], op_bytes[30:25], write_word[46:31],
    //        not_ready_in[47], bus_data_in[63:48], irq_lines[67:64], zero fill
    input  logic [cbms_pkg::IN_W-1:0]  s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [cbms_pkg::CMD_W-1:0] s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // tdata: addr_drive[0], addr_out[24:1], size_strobe[26:25], write_strobe[28:27],
    //        data_drive[29], data_out[45:30], idle_flag[46], has_read_data[47],
    //        interrupt_bits[53:48], popped_word[69:54], overflow_flag[70], zero fill
    output logic [cbms_pkg::OUT_W-1:0] m_axis_tdata
);

    import cbms_pkg::*;

    localparam int PTR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int CMP_W = (CNT_W > DIDX_W) ? CNT_W : DIDX_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_WORDS);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_BEGIN   = 3'd1,
        PH_WAIT    = 3'd2,
        PH_ACTIVE  = 3'd3,
        PH_CLEANUP = 3'd4
    } phase_t;

    // Ring index a + b, wrapped once at the depth; a stays below the depth.
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W:0]   b);
        logic [PTR_W+1:0] s;
        s = (PTR_W+2)'(a) + (PTR_W+2)'(b);
        if (s >= (PTR_W+2)'(MAX_WORDS))
        begin
            s = s - (PTR_W+2)'(MAX_WORDS);
        end
        return s[PTR_W-1:0];
    endfunction

    // Control state
    phase_t                     phase_reg, phase_next;
    logic                       op_valid_reg, op_valid_next;
    logic                       op_read_reg, op_read_next;
    logic [ADDR_BITS-1:0]       base_reg, base_next;
    logic signed [BYTES_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [PTR_W-1:0]           head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [OFFS_W-1:0]          offset_reg, offset_next;
    logic signed [DIDX_W-1:0]   didx_reg, didx_next;
    logic [1:0]                 size_mode_reg, size_mode_next;
    logic [1:0]                 lane_mode_reg, lane_mode_next;
    logic                       wait_reg, wait_next;
    logic [5:0]                 irq_latch_reg, irq_latch_next;

    // Pipeline stages
    logic      s1_valid_reg;
    out_word_t s1_word_reg, s1_word_next;
    logic      s1_dsel_reg, s1_dsel_next;
    logic      s1_psel_reg, s1_psel_next;
    logic      out_valid_reg;
    out_word_t out_word_reg, out_word_next;

    // Buffer RAM port
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [PTR_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    in_word_t in_w;
    cmd_t     cmd;
    logic     accept;
    logic     s2_free;
    logic     s1_move;

    logic                      push_req;
    logic [WORD_W-1:0]         push_data;
    logic                      ovf;
    logic signed [BYTES_W-1:0] bl_adv;
    logic                      didx_in_range;

    assign in_w = in_word_t'(s_axis_tdata);
    assign cmd  = cmd_t'(s_axis_tuser);

    assign s2_free       = !out_valid_reg || m_axis_tready;
    assign s1_move       = s1_valid_reg && s2_free;
    assign s_axis_tready = !s1_valid_reg || s2_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign bl_adv = bytes_left_reg - BYTES_W'(2);
    assign didx_in_range = !didx_reg[DIDX_W-1] &&
                           (CMP_W'($unsigned(didx_reg)) < CMP_W'(count_reg));

    always_comb
    begin
        phase_next      = phase_reg;
        op_valid_next   = op_valid_reg;
        op_read_next    = op_read_reg;
        base_next       = base_reg;
        bytes_left_next = bytes_left_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        offset_next     = offset_reg;
        didx_next       = didx_reg;
        size_mode_next  = size_mode_reg;
        lane_mode_next  = lane_mode_reg;
        wait_next       = wait_reg;
        irq_latch_next  = irq_latch_reg;

        push_req     = 1'b0;
        push_data    = in_w.write_word;
        ovf          = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = ring_add(head_reg, (PTR_W+1)'(count_reg));
        ram_wdata    = push_data;
        ram_raddr    = head_reg;
        s1_dsel_next = 1'b0;
        s1_psel_next = 1'b0;
        s1_word_next = '0;

        case (cmd)
            CMD_START:
            begin
                base_next       = in_w.op_address;
                op_read_next    = in_w.op_is_read;
                bytes_left_next = signed'({1'b0, in_w.op_bytes});
                op_valid_next   = 1'b1;
                head_next       = '0;
                count_next      = '0;
            end
            CMD_LOAD:
            begin
                push_req  = 1'b1;
                push_data = in_w.write_word;
            end
            CMD_TICK:
            begin
                if (phase_reg == PH_BEGIN || phase_reg == PH_WAIT || phase_reg == PH_ACTIVE)
                begin
                    s1_word_next.addr_drive   = 1'b1;
                    s1_word_next.addr_out     = (base_reg + ADDR_BITS'(offset_reg)) & ADDR_MASK;
                    s1_word_next.size_strobe  = size_mode_reg;
                    s1_word_next.write_strobe = lane_mode_reg;
                end
                if (phase_reg != PH_IDLE && !op_read_reg)
                begin
                    s1_word_next.data_drive = 1'b1;
                    s1_dsel_next = didx_in_range;
                    ram_raddr = ring_add(head_reg, (PTR_W+1)'($unsigned(didx_reg)));
                end

                irq_latch_next = {in_w.irq_lines, 2'b00};
                wait_next      = in_w.not_ready_in;
                push_data      = in_w.bus_data_in;

                case (phase_reg)
                    PH_BEGIN:
                    begin
                        phase_next = PH_WAIT;
                    end
                    PH_WAIT:
                    begin
                        if (!in_w.not_ready_in)
                        begin
                            phase_next      = PH_ACTIVE;
                            offset_next     = offset_reg + OFFS_W'(2);
                            bytes_left_next = bl_adv;
                            if (!op_read_reg)
                            begin
                                didx_next = didx_reg + DIDX_W'(1);
                                if (bl_adv <= 0)
                                begin
                                    phase_next = PH_CLEANUP;
                                end
                            end
                        end
                    end
                    PH_ACTIVE:
                    begin
                        if (in_w.not_ready_in)
                        begin
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            offset_next     = offset_reg + OFFS_W'(2);
                            didx_next       = didx_reg + DIDX_W'(1);
                            push_req        = op_read_reg;
                            bytes_left_next = bl_adv;
                            if (bl_adv <= 0)
                            begin
                                phase_next = PH_CLEANUP;
                            end
                        end
                    end
                    PH_CLEANUP:
                    begin
                        push_req   = op_read_reg;
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        if (op_valid_reg && bytes_left_reg > 0)
                        begin
                            phase_next     = PH_BEGIN;
                            offset_next    = '0;
                            didx_next      = '1;
                            size_mode_next = (bytes_left_reg > 2) ? SIZE_WIDE : SIZE_NARROW;
                            if (op_read_reg)
                            begin
                                lane_mode_next = LANE_NONE;
                            end
                            else if (bytes_left_reg == 1)
                            begin
                                lane_mode_next = base_reg[0] ? LANE_HIGH : LANE_LOW;
                            end
                            else
                            begin
                                lane_mode_next = LANE_BOTH;
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                if (op_valid_reg && count_reg != '0)
                begin
                    s1_psel_next = 1'b1;
                    ram_raddr    = head_reg;
                    head_next    = ring_add(head_reg, (PTR_W+1)'(1));
                    count_next   = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1) && bytes_left_reg < 0)
                    begin
                        op_valid_next = 1'b0;
                    end
                end
            end
        endcase

        // Pushes never coincide with a start, so count_reg is the current fill.
        ram_wdata = push_data;
        if (push_req)
        begin
            if (count_reg == FULL_COUNT)
            begin
                ovf = 1'b1;
            end
            else
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end

        s1_word_next.idle_flag      = (phase_next == PH_IDLE) && !wait_next;
        s1_word_next.has_read_data  = op_read_next && op_valid_next && (count_next != '0);
        s1_word_next.interrupt_bits = irq_latch_next;
        s1_word_next.overflow_flag  = ovf;
    end

    assign ram_re = accept && (s1_dsel_next || s1_psel_next);

    cbms_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_buf_ram (
        .clk   (clk),
        .we    (ram_we && accept),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            op_valid_reg   <= 1'b0;
            op_read_reg    <= 1'b0;
            base_reg       <= '0;
            bytes_left_reg <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            offset_reg     <= '0;
            didx_reg       <= '0;
            size_mode_reg  <= '0;
            lane_mode_reg  <= '0;
            wait_reg       <= 1'b0;
            irq_latch_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            op_valid_reg   <= op_valid_next;
            op_read_reg    <= op_read_next;
            base_reg       <= base_next;
            bytes_left_reg <= bytes_left_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            offset_reg     <= offset_next;
            didx_reg       <= didx_next;
            size_mode_reg  <= size_mode_next;
            lane_mode_reg  <= lane_mode_next;
            wait_reg       <= wait_next;
            irq_latch_reg  <= irq_latch_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The RAM read data belongs to the word in the read stage and holds until it moves on.
    always_comb
    begin
        out_word_next             = s1_word_reg;
        out_word_next.data_out    = s1_dsel_reg ? ram_rdata : '0;
        out_word_next.popped_word = s1_psel_reg ? ram_rdata : '0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= s1_word_next;
            s1_dsel_reg <= s1_dsel_next;
            s1_psel_reg <= s1_psel_next;
        end
        if (s1_move)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_word_reg);

endmodule

[sv/cbms_checker.sv]
// Port-level checker for the CPU bus master sequencer, bound to the top level.
module cbms_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [cbms_pkg::IN_W-1:0]  s_axis_tdata,
    input logic [cbms_pkg::CMD_W-1:0] s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [cbms_pkg::OUT_W-1:0] m_axis_tdata
);

    import cbms_pkg::*;

    out_word_t ow;

    assign ow = out_word_t'(m_axis_tdata);

    // A stalled result word must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

    // Address, size and lanes are zero on words that do not drive the address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !ow.addr_drive |->
            ow.addr_out == '0 && ow.size_strobe == '0 && ow.write_strobe == '0)
    else $error("address fields set without address drive");

    // A driven address always carries a size that a begin phase set up.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ow.addr_drive |->
            ow.size_strobe == SIZE_NARROW || ow.size_strobe == SIZE_WIDE)
    else $error("driven address with invalid size code");

    // Write data is zero unless it is driven, and driven data never comes with a pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (!ow.data_drive || ow.popped_word != '0) |->
            ow.data_out == '0)
    else $error("write data without data drive");

    // The latched interrupts sit above bit 1 and the address is always even.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ow.interrupt_bits[1:0] == 2'b00 && !ow.addr_out[0])
    else $error("interrupt or address alignment broken");

endmodule

bind cpu_bus_master_sequencer cbms_checker u_cbms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[test/tb.sv]
// Testbench for the CPU bus master sequencer: directed and random streams checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import cbms_pkg::*;

    typedef enum logic [2:0] {
        PHASE_IDLE    = 3'd0,
        PHASE_BEGIN   = 3'd1,
        PHASE_WAIT    = 3'd2,
        PHASE_ACTIVE  = 3'd3,
        PHASE_CLEANUP = 3'd4
    } phase_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0] s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    // Predicted sequencer state, updated as each word is accepted.
    phase_t             cur_phase;
    bit                 op_valid_q;
    bit                 op_read_q;
    logic [23:0]        base_q;
    logic signed [6:0]  bytes_left_q;
    logic [WORD_W-1:0]  word_buf [MAX_WORDS_DEF];
    logic [3:0]         head_q;
    logic [4:0]         count_q;
    logic [6:0]         offset_q;
    logic signed [5:0]  didx_q;
    logic [1:0]         size_q;
    logic [1:0]         lane_q;
    bit                 wait_q;
    logic [5:0]         irq_q;

    out_word_t pending_results [$];
    int        items_sent = 0;
    int        mismatches = 0;
    bit        full_rate = 1'b0;
    int        hold_left = 0;

    cpu_bus_master_sequencer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int stall_len();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic bit buf_push(logic [WORD_W-1:0] wd);
        if (count_q >= MAX_WORDS_DEF)
            return 1'b0;
        word_buf[(int'(head_q) + int'(count_q)) % MAX_WORDS_DEF] = wd;
        count_q++;
        return 1'b1;
    endfunction

    function automatic out_word_t sequencer_step(cmd_t c, in_word_t w);
        out_word_t   r;
        int          di;
        logic [23:0] sum;
        r = '0;
        case (c)
            CMD_START:
            begin
                base_q       = w.op_address;
                op_read_q    = w.op_is_read;
                bytes_left_q = {1'b0, w.op_bytes};
                op_valid_q   = 1'b1;
                head_q       = '0;
                count_q      = '0;
            end
            CMD_LOAD:
            begin
                if (!buf_push(w.write_word))
                    r.overflow_flag = 1'b1;
            end
            CMD_TICK:
            begin
                if (cur_phase == PHASE_BEGIN || cur_phase == PHASE_WAIT
                        || cur_phase == PHASE_ACTIVE)
                begin
                    sum            = base_q + {17'd0, offset_q};
                    r.addr_drive   = 1'b1;
                    r.addr_out     = sum & ADDR_MASK;
                    r.size_strobe  = size_q;
                    r.write_strobe = lane_q;
                end
                if (cur_phase != PHASE_IDLE && !op_read_q)
                begin
                    r.data_drive = 1'b1;
                    di = didx_q;
                    // The write word is picked relative to the oldest buffered word.
                    if (di >= 0 && di < int'(count_q))
                        r.data_out = word_buf[(int'(head_q) + di) % MAX_WORDS_DEF];
                end
                irq_q  = {w.irq_lines, 2'b00};
                wait_q = w.not_ready_in;
                case (cur_phase)
                    PHASE_BEGIN:
                        cur_phase = PHASE_WAIT;
                    PHASE_WAIT:
                    begin
                        if (!w.not_ready_in)
                        begin
                            cur_phase    = PHASE_ACTIVE;
                            offset_q     = offset_q + 7'd2;
                            bytes_left_q = bytes_left_q - 7'sd2;
                            if (!op_read_q)
                            begin
                                didx_q = didx_q + 6'sd1;
                                if (bytes_left_q <= 0)
                                    cur_phase = PHASE_CLEANUP;
                            end
                        end
                    end
                    PHASE_ACTIVE:
                    begin
                        if (w.not_ready_in)
                            cur_phase = PHASE_WAIT;
                        else
                        begin
                            offset_q = offset_q + 7'd2;
                            didx_q   = didx_q + 6'sd1;
                            if (op_read_q && !buf_push(w.bus_data_in))
                                r.overflow_flag = 1'b1;
                            bytes_left_q = bytes_left_q - 7'sd2;
                            if (bytes_left_q <= 0)
                                cur_phase = PHASE_CLEANUP;
                        end
                    end
                    PHASE_CLEANUP:
                    begin
                        if (op_read_q && !buf_push(w.bus_data_in))
                            r.overflow_flag = 1'b1;
                        cur_phase = PHASE_IDLE;
                    end
                    default:
                    begin
                        cur_phase = PHASE_IDLE;
                        if (op_valid_q && bytes_left_q > 0)
                        begin
                            cur_phase = PHASE_BEGIN;
                            offset_q  = '0;
                            didx_q    = -6'sd1;
                            size_q    = (bytes_left_q > 2) ? SIZE_WIDE : SIZE_NARROW;
                            if (op_read_q)
                                lane_q = LANE_NONE;
                            else if (bytes_left_q == 1)
                                lane_q = base_q[0] ? LANE_HIGH : LANE_LOW;
                            else
                                lane_q = LANE_BOTH;
                        end
                    end
                endcase
            end
            default:
            begin
                if (op_valid_q && count_q != 0)
                begin
                    r.popped_word = word_buf[head_q];
                    head_q  = head_q + 4'd1;
                    count_q = count_q - 5'd1;
                    if (count_q == 0 && bytes_left_q < 0)
                        op_valid_q = 1'b0;
                end
            end
        endcase
        r.idle_flag      = (cur_phase == PHASE_IDLE) && !wait_q;
        r.has_read_data  = op_read_q && op_valid_q && (count_q != 0);
        r.interrupt_bits = irq_q;
        return r;
    endfunction

    function automatic in_word_t random_bus_word();
        in_word_t w;
        w.pad          = '0;
        w.op_address   = $urandom_range(0, 24'hffffff);
        w.op_is_read   = $urandom_range(0, 1);
        w.op_bytes     = $urandom_range(0, 63);
        w.write_word   = $urandom_range(0, 16'hffff);
        w.not_ready_in = $urandom_range(0, 1);
        w.bus_data_in  = $urandom_range(0, 16'hffff);
        w.irq_lines    = $urandom_range(0, 15);
        return w;
    endfunction

    task automatic send_item(cmd_t c, in_word_t w);
        int        gap;
        out_word_t predicted;
        gap = (!full_rate && $urandom_range(0, 99) < 35) ? stall_len() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= c;
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        predicted = sequencer_step(c, w);
        pending_results = {pending_results, predicted};
        items_sent++;
    endtask

    // Drops valid right after the last accepted word so nothing is taken twice.
    task automatic wait_for_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic start_op(logic [23:0] a, bit rd, logic [5:0] nb);
        in_word_t w;
        w = random_bus_word();
        w.op_address = a;
        w.op_is_read = rd;
        w.op_bytes   = nb;
        send_item(CMD_START, w);
    endtask

    task automatic load_word(logic [WORD_W-1:0] d);
        in_word_t w;
        w = random_bus_word();
        w.write_word = d;
        send_item(CMD_LOAD, w);
    endtask

    task automatic tick(bit nr, logic [WORD_W-1:0] d, logic [3:0] irq);
        in_word_t w;
        w = random_bus_word();
        w.not_ready_in = nr;
        w.bus_data_in  = d;
        w.irq_lines    = irq;
        send_item(CMD_TICK, w);
    endtask

    task automatic pop_word();
        send_item(CMD_POP, random_bus_word());
    endtask

    task automatic tick_random();
        tick($urandom_range(0, 99) < 20, $urandom_range(0, 16'hffff), $urandom_range(0, 15));
    endtask

    // One operation from start to idle, with a few stray commands mixed in.
    task automatic run_operation();
        int          n;
        int          guard;
        int          r;
        logic [5:0]  nb;
        r = $urandom_range(0, 99);
        if (r < 5)
            nb = 0;
        else if (r < 85)
            nb = $urandom_range(1, 8);
        else if (r < 95)
            nb = $urandom_range(9, 32);
        else
            nb = $urandom_range(33, 63);
        start_op($urandom_range(0, 24'hffffff), $urandom_range(0, 1), nb);
        if (!op_read_q)
            n = ($urandom_range(0, 99) < 8) ? $urandom_range(15, 20) : $urandom_range(0, 6);
        else
            n = $urandom_range(0, 1);
        repeat (n) load_word($urandom_range(0, 16'hffff));
        tick_random();
        guard = 0;
        while (cur_phase != PHASE_IDLE && guard < 400)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                start_op($urandom_range(0, 24'hffffff), $urandom_range(0, 1),
                         $urandom_range(0, 12));
            else if (r < 5)
                pop_word();
            else if (r < 7)
                load_word($urandom_range(0, 16'hffff));
            else
                tick_random();
            guard++;
        end
        n = $urandom_range(0, int'(count_q) + 2);
        repeat (n) pop_word();
        if ($urandom_range(0, 99) < 4)
            wait_for_results();
    endtask

    task automatic test_directed();
        pop_word();
        tick(1'b1, 16'hffff, 4'hf);
        tick(1'b0, 16'h0000, 4'h0);
        // One-byte write at an odd address uses the high lane only.
        start_op(24'hffffff, 1'b0, 6'd1);
        load_word(16'hffff);
        load_word(16'h0000);
        tick(1'b0, 16'h1234, 4'h1);
        tick(1'b0, 16'h1234, 4'h2);
        tick(1'b1, 16'h1234, 4'h4);
        tick(1'b0, 16'h1234, 4'h8);
        tick(1'b0, 16'h1234, 4'h0);
        pop_word();
        pop_word();
        pop_word();
        start_op(24'h000000, 1'b1, 6'd6);
        tick(1'b0, 16'h0000, 4'h0);
        tick(1'b0, 16'h0000, 4'h0);
        tick(1'b0, 16'hffff, 4'h0);
        tick(1'b1, 16'h0000, 4'h3);
        tick(1'b0, 16'h0000, 4'h0);
        tick(1'b0, 16'hffff, 4'ha);
        // A new operation replaces the old one while the old one is still in cleanup.
        start_op(24'h800000, 1'b0, 6'd63);
        tick(1'b0, 16'h5555, 4'h5);
        start_op(24'h000002, 1'b0, 6'd0);
        tick(1'b0, 16'haaaa, 4'hf);
        wait_for_results();
    endtask

    task automatic test_operations(int target);
        while (items_sent < target)
            run_operation();
        wait_for_results();
    endtask

    task automatic test_back_to_back(int target);
        full_rate = 1'b1;
        while (items_sent < target)
            run_operation();
        wait_for_results();
        full_rate = 1'b0;
    endtask

    task automatic test_random_commands(int target);
        while (items_sent < target)
            send_item(cmd_t'($urandom_range(0, 3)), random_bus_word());
        wait_for_results();
    endtask

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(negedge clk)
    begin
        if (hold_left == 0 && !full_rate && $urandom_range(0, 99) < 25)
            hold_left = stall_len();
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_results
        out_word_t got;
        out_word_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %0h", m_axis_tdata);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("addr_drive", want.addr_drive, got.addr_drive);
                check_field("addr_out", want.addr_out, got.addr_out);
                check_field("size_strobe", want.size_strobe, got.size_strobe);
                check_field("write_strobe", want.write_strobe, got.write_strobe);
                check_field("data_drive", want.data_drive, got.data_drive);
                check_field("data_out", want.data_out, got.data_out);
                check_field("idle_flag", want.idle_flag, got.idle_flag);
                check_field("has_read_data", want.has_read_data, got.has_read_data);
                check_field("interrupt_bits", want.interrupt_bits, got.interrupt_bits);
                check_field("popped_word", want.popped_word, got.popped_word);
                check_field("overflow_flag", want.overflow_flag, got.overflow_flag);
                check_field("fill", want.pad, got.pad);
            end
        end
    end

    initial
    begin
        cur_phase    = PHASE_IDLE;
        op_valid_q   = 1'b0;
        op_read_q    = 1'b0;
        base_q       = '0;
        bytes_left_q = '0;
        head_q       = '0;
        count_q      = '0;
        offset_q     = '0;
        didx_q       = '0;
        size_q       = '0;
        lane_q       = '0;
        wait_q       = 1'b0;
        irq_q        = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_operations(1000);
        test_back_to_back(1250);
        test_random_commands(1450);

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
sv/cbms_pkg.sv
sv/cbms_ram.sv
sv/cpu_bus_master_sequencer.sv
sv/cbms_checker.sv
test/tb.sv
